// ===== hdl/pct_pkg.sv =====
// Shared types and constants for the prescaled compare timer.
`timescale 1ns / 1ps

package pct_pkg;

    localparam int unsigned DataW = 16;
    localparam int unsigned AddrW = 16;
    localparam int unsigned PscW  = 8;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    localparam logic [AddrW-1:0] OFF_COUNT   = 16'd0;
    localparam logic [AddrW-1:0] OFF_CTRL    = 16'd1;
    localparam logic [AddrW-1:0] OFF_STATUS  = 16'd2;
    localparam logic [AddrW-1:0] OFF_COMPARE = 16'd3;

    localparam int unsigned CTRL_EN  = 0;
    localparam int unsigned CTRL_PSL = 1;
    localparam int unsigned CTRL_PSH = 2;
    localparam int unsigned CTRL_AR  = 3;
    localparam int unsigned CTRL_OIE = 4;
    localparam int unsigned CTRL_CIE = 5;

    localparam int unsigned STAT_OVF = 0;
    localparam int unsigned STAT_CMF = 1;

    localparam logic [DataW-1:0] UNMAPPED = 16'hFFFF;
    localparam logic [DataW-1:0] CNT_MAX  = 16'hFFFF;

    typedef enum logic [1:0] {
        PSC_DIV1   = 2'd0,
        PSC_DIV4   = 2'd1,
        PSC_DIV16  = 2'd2,
        PSC_DIV256 = 2'd3
    } t_psc_sel;

    typedef struct packed {
        t_func             func;
        logic [AddrW-1:0]  address;
        logic [DataW-1:0]  write_data;
    } t_req;

    typedef struct packed {
        logic [DataW-1:0] read_data;
        logic             irq;
    } t_rsp;

endpackage

// ===== hdl/prescaled_compare_timer.sv =====
// Top level of the prescaled compare timer: handshake and result register.
`timescale 1ns / 1ps

// A 16-bit up-counting timer with COUNT, CTRL, STATUS and COMPARE at
// base_address + 0..3. Each transfer is a tick, a bus read, a bus write or a
// no-op and yields one result. One transfer is taken every cycle that the output
// register is free or being taken; its result appears in the output register on
// the next cycle. The input stalls only while that register holds a result that
// has not been taken. Timer state is updated at the edge that accepts the
// transfer, so back-to-back operations see each other's effects in order.
module prescaled_compare_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_address,
    input  logic [15:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_read_data,
    output logic        o_irq,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    pct_pkg::t_req req;
    pct_pkg::t_rsp rsp;
    logic          accept;
    logic          r_out_valid;
    pct_pkg::t_rsp r_rsp;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign req.func       = pct_pkg::t_func'(i_func);
    assign req.address    = i_address;
    assign req.write_data = i_write_data;

    pct_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_req       (req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_rsp.read_data;
    assign o_irq       = r_rsp.irq;

endmodule

// ===== hdl/pct_core.sv =====
// Timer register file, prescaler and counter, one operation per enabled cycle.
`timescale 1ns / 1ps

module pct_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  pct_pkg::t_req            i_req,
    input  logic                     i_cfg_we,
    input  logic [pct_pkg::AddrW-1:0] i_cfg_wdata,
    output pct_pkg::t_rsp            o_rsp
);

    logic [pct_pkg::AddrW-1:0] r_base;
    logic [pct_pkg::DataW-1:0] r_cnt,    n_cnt;
    logic [pct_pkg::DataW-1:0] r_ctrl,   n_ctrl;
    logic [1:0]                r_stat,   n_stat;
    logic [pct_pkg::DataW-1:0] r_cmp,    n_cmp;
    logic [pct_pkg::DataW-1:0] r_reload, n_reload;
    logic [pct_pkg::PscW-1:0]  r_psc,    n_psc;
    logic                      r_irq,    n_irq;

    logic [pct_pkg::AddrW-1:0] off;
    logic [pct_pkg::PscW:0]    psc_sum;
    logic [pct_pkg::PscW:0]    psc_top;
    logic [pct_pkg::DataW-1:0] cnt_inc;
    logic [pct_pkg::DataW-1:0] rd;

    assign off     = i_req.address - r_base;
    assign psc_sum = {1'b0, r_psc} + {{pct_pkg::PscW{1'b0}}, 1'b1};
    assign cnt_inc = r_cnt + {{(pct_pkg::DataW-1){1'b0}}, 1'b1};

    always_comb begin
        unique case (pct_pkg::t_psc_sel'(r_ctrl[pct_pkg::CTRL_PSH:pct_pkg::CTRL_PSL]))
            pct_pkg::PSC_DIV1:   psc_top = 9'd1;
            pct_pkg::PSC_DIV4:   psc_top = 9'd4;
            pct_pkg::PSC_DIV16:  psc_top = 9'd16;
            pct_pkg::PSC_DIV256: psc_top = 9'd256;
            default:             psc_top = 9'd256;
        endcase
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_ctrl   = r_ctrl;
        n_stat   = r_stat;
        n_cmp    = r_cmp;
        n_reload = r_reload;
        n_psc    = r_psc;
        n_irq    = r_irq;
        rd       = '0;
        unique case (i_req.func)
            pct_pkg::FUNC_TICK: begin
                n_irq = (r_stat[pct_pkg::STAT_OVF] & r_ctrl[pct_pkg::CTRL_OIE])
                      | (r_stat[pct_pkg::STAT_CMF] & r_ctrl[pct_pkg::CTRL_CIE]);
                if (r_ctrl[pct_pkg::CTRL_EN]) begin
                    if (psc_sum >= psc_top) begin
                        n_psc = '0;
                        if (cnt_inc == r_cmp) begin
                            n_stat[pct_pkg::STAT_CMF] = 1'b1;
                        end
                        if (r_cnt == pct_pkg::CNT_MAX) begin
                            n_stat[pct_pkg::STAT_OVF] = 1'b1;
                            if (r_ctrl[pct_pkg::CTRL_AR]) begin
                                n_cnt = r_reload;
                            end else begin
                                n_ctrl[pct_pkg::CTRL_EN] = 1'b0;
                            end
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end else begin
                        n_psc = psc_sum[pct_pkg::PscW-1:0];
                    end
                end
            end
            pct_pkg::FUNC_READ: begin
                priority if (off == pct_pkg::OFF_COUNT) begin
                    rd = r_cnt;
                end else if (off == pct_pkg::OFF_CTRL) begin
                    rd = r_ctrl;
                end else if (off == pct_pkg::OFF_STATUS) begin
                    rd = {{(pct_pkg::DataW-2){1'b0}}, r_stat};
                end else if (off == pct_pkg::OFF_COMPARE) begin
                    rd = r_cmp;
                end else begin
                    rd = pct_pkg::UNMAPPED;
                end
            end
            pct_pkg::FUNC_WRITE: begin
                priority if (off == pct_pkg::OFF_COUNT) begin
                    n_cnt    = i_req.write_data;
                    n_reload = i_req.write_data;
                end else if (off == pct_pkg::OFF_CTRL) begin
                    n_ctrl = i_req.write_data;
                end else if (off == pct_pkg::OFF_STATUS) begin
                    n_stat = r_stat & ~i_req.write_data[1:0];
                end else if (off == pct_pkg::OFF_COMPARE) begin
                    n_cmp = i_req.write_data;
                end
            end
            pct_pkg::FUNC_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_cnt    <= '0;
            r_ctrl   <= '0;
            r_stat   <= '0;
            r_cmp    <= '0;
            r_reload <= '0;
            r_psc    <= '0;
            r_irq    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (i_en) begin
                r_cnt    <= n_cnt;
                r_ctrl   <= n_ctrl;
                r_stat   <= n_stat;
                r_cmp    <= n_cmp;
                r_reload <= n_reload;
                r_psc    <= n_psc;
                r_irq    <= n_irq;
            end
        end
    end

    assign o_rsp.read_data = rd;
    assign o_rsp.irq       = n_irq;

endmodule

// ===== bench/timer_checker.sv =====
// Watches both channels of the timer, predicts every result and compares it.
`timescale 1ns / 1ps

module timer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_address,
    input  logic [15:0] i_write_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_read_data,
    input  logic        i_irq,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_fails,
    output int          o_pending,
    output int          o_checked
);

    logic [15:0] base_q;
    logic [15:0] cnt_q;
    logic [15:0] ctrl_q;
    logic [1:0]  stat_q;
    logic [15:0] cmp_q;
    logic [15:0] rld_q;
    logic [15:0] psc_q;
    logic        irq_q;

    pct_pkg::t_rsp expected_rsp[$];

    function automatic void timer_tick();
        logic [15:0] div_top;
        logic [15:0] nxt;
        irq_q = (stat_q[pct_pkg::STAT_OVF] & ctrl_q[pct_pkg::CTRL_OIE])
              | (stat_q[pct_pkg::STAT_CMF] & ctrl_q[pct_pkg::CTRL_CIE]);
        if (!ctrl_q[pct_pkg::CTRL_EN])
            return;
        psc_q = psc_q + 16'd1;
        case (pct_pkg::t_psc_sel'(ctrl_q[pct_pkg::CTRL_PSH:pct_pkg::CTRL_PSL]))
            pct_pkg::PSC_DIV1:  div_top = 16'd1;
            pct_pkg::PSC_DIV4:  div_top = 16'd4;
            pct_pkg::PSC_DIV16: div_top = 16'd16;
            default:            div_top = 16'd256;
        endcase
        if (psc_q < div_top)
            return;
        psc_q = '0;
        nxt = cnt_q + 16'd1;
        if (nxt == cmp_q)
            stat_q[pct_pkg::STAT_CMF] = 1'b1;
        if (cnt_q == pct_pkg::CNT_MAX) begin
            stat_q[pct_pkg::STAT_OVF] = 1'b1;
            if (ctrl_q[pct_pkg::CTRL_AR])
                cnt_q = rld_q;
            else
                ctrl_q[pct_pkg::CTRL_EN] = 1'b0;
        end else begin
            cnt_q = nxt;
        end
    endfunction

    function automatic pct_pkg::t_rsp apply_transfer(pct_pkg::t_func f, logic [15:0] addr,
                                                     logic [15:0] data);
        pct_pkg::t_rsp r;
        logic [15:0] off;
        r.read_data = '0;
        off = addr - base_q;
        case (f)
            pct_pkg::FUNC_TICK: timer_tick();
            pct_pkg::FUNC_READ: begin
                case (off)
                    pct_pkg::OFF_COUNT:   r.read_data = cnt_q;
                    pct_pkg::OFF_CTRL:    r.read_data = ctrl_q;
                    pct_pkg::OFF_STATUS:  r.read_data = {14'd0, stat_q};
                    pct_pkg::OFF_COMPARE: r.read_data = cmp_q;
                    default:              r.read_data = pct_pkg::UNMAPPED;
                endcase
            end
            pct_pkg::FUNC_WRITE: begin
                case (off)
                    pct_pkg::OFF_COUNT: begin
                        cnt_q = data;
                        rld_q = data;
                    end
                    pct_pkg::OFF_CTRL:    ctrl_q = data;
                    pct_pkg::OFF_STATUS:  stat_q = stat_q & ~data[1:0];
                    pct_pkg::OFF_COMPARE: cmp_q = data;
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.irq = irq_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        pct_pkg::t_rsp want;
        if (!i_rst_n) begin
            base_q = '0;
            cnt_q  = '0;
            ctrl_q = '0;
            stat_q = '0;
            cmp_q  = '0;
            rld_q  = '0;
            psc_q  = '0;
            irq_q  = 1'b0;
            expected_rsp.delete();
        end else begin
            // results leave before the new transfer is predicted
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (expected_rsp.size() == 0) begin
                    $error("result with no transfer pending: read_data %h irq %b",
                           i_read_data, i_irq);
                    o_fails++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (i_read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data, i_read_data);
                        o_fails++;
                    end
                    if (i_irq !== want.irq) begin
                        $error("irq: expected %b, got %b", want.irq, i_irq);
                        o_fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_rsp.push_back(apply_transfer(pct_pkg::t_func'(i_func), i_address,
                                                      i_write_data));
            if (i_cfg_we)
                base_q = i_cfg_wdata;
        end
        o_pending <= expected_rsp.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the prescaled compare timer: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned ItemsPerSeg = 350;
    localparam int unsigned NumSegs     = 5;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [1:0]  func       = pct_pkg::FUNC_TICK;
    logic [15:0] address    = '0;
    logic [15:0] write_data = '0;
    logic        out_ready  = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [15:0] cfg_wdata  = '0;
    logic        in_ready;
    logic        out_valid;
    logic [15:0] read_data;
    logic        irq;

    int fails;
    int pending;
    int checked;
    int cycles;
    int snd_idle = 32;
    int rcv_idle = 46;
    int n_tick;
    int n_read;
    int n_write;
    int n_none;
    logic [15:0] cur_base = '0;

    prescaled_compare_timer i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_func       (func),
        .i_address    (address),
        .i_write_data (write_data),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_read_data  (read_data),
        .o_irq        (irq),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata)
    );

    timer_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_func       (func),
        .i_address    (address),
        .i_write_data (write_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_read_data  (read_data),
        .i_irq        (irq),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fails      (fails),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic logic [15:0] ctl(logic en, pct_pkg::t_psc_sel ps, logic ar, logic oie,
                                        logic cie);
        logic [15:0] w;
        w = '0;
        w[pct_pkg::CTRL_EN] = en;
        w[pct_pkg::CTRL_PSH:pct_pkg::CTRL_PSL] = ps;
        w[pct_pkg::CTRL_AR] = ar;
        w[pct_pkg::CTRL_OIE] = oie;
        w[pct_pkg::CTRL_CIE] = cie;
        return w;
    endfunction

    task automatic put_op(pct_pkg::t_func f, logic [15:0] off, logic [15:0] d);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        address    <= cur_base + off;
        write_data <= d;
        case (f)
            pct_pkg::FUNC_TICK:  n_tick++;
            pct_pkg::FUNC_READ:  n_read++;
            pct_pkg::FUNC_WRITE: n_write++;
            default:             n_none++;
        endcase
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_base(logic [15:0] b);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= b;
        cur_base  = b;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic rand_op();
        int sel;
        pct_pkg::t_func f;
        logic [15:0] off;
        logic [15:0] d;
        int r;
        sel = $urandom_range(99);
        f = (sel < 48) ? pct_pkg::FUNC_TICK :
            (sel < 72) ? pct_pkg::FUNC_READ :
            (sel < 95) ? pct_pkg::FUNC_WRITE : pct_pkg::FUNC_NONE;
        off = ($urandom_range(9) < 8) ? 16'($urandom_range(3)) : 16'($urandom);
        d = 16'($urandom);
        if (f == pct_pkg::FUNC_WRITE) begin
            case (off)
                pct_pkg::OFF_COUNT: begin
                    if ($urandom_range(1))
                        d = pct_pkg::CNT_MAX - 16'($urandom_range(15));
                end
                pct_pkg::OFF_CTRL: begin
                    d[pct_pkg::CTRL_EN] = ($urandom_range(7) != 0);
                    r = $urandom_range(19);
                    d[pct_pkg::CTRL_PSH:pct_pkg::CTRL_PSL] =
                        (r < 12) ? pct_pkg::PSC_DIV1 :
                        (r < 17) ? pct_pkg::PSC_DIV4 :
                        (r < 19) ? pct_pkg::PSC_DIV16 : pct_pkg::PSC_DIV256;
                end
                pct_pkg::OFF_COMPARE: begin
                    r = $urandom_range(3);
                    if (r == 0)
                        d = 16'($urandom_range(3));
                    else if (r == 1)
                        d = pct_pkg::CNT_MAX - 16'($urandom_range(15));
                end
                default: ;
            endcase
        end
        put_op(f, off, d);
    endtask

    initial begin
        logic [15:0] seg_base [NumSegs];
        seg_base[0] = 16'hFFFF;
        seg_base[1] = 16'($urandom);
        seg_base[2] = 16'hFFFE;
        seg_base[3] = 16'h0000;
        seg_base[4] = 16'($urandom);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, unmapped access and the unused code
        put_op(pct_pkg::FUNC_READ, pct_pkg::OFF_COUNT, '0);
        put_op(pct_pkg::FUNC_READ, pct_pkg::OFF_CTRL, '0);
        put_op(pct_pkg::FUNC_READ, pct_pkg::OFF_STATUS, '0);
        put_op(pct_pkg::FUNC_READ, pct_pkg::OFF_COMPARE, '0);
        put_op(pct_pkg::FUNC_READ, 16'd4, '0);
        put_op(pct_pkg::FUNC_NONE, 16'hFFFF, 16'hFFFF);
        // compare hit on the wrap to zero, together with overflow and reload
        put_op(pct_pkg::FUNC_WRITE, pct_pkg::OFF_COUNT, 16'hFFFE);
        put_op(pct_pkg::FUNC_WRITE, pct_pkg::OFF_COMPARE, 16'h0000);
        put_op(pct_pkg::FUNC_WRITE, pct_pkg::OFF_CTRL,
               ctl(1'b1, pct_pkg::PSC_DIV1, 1'b1, 1'b1, 1'b1));
        repeat (3) put_op(pct_pkg::FUNC_TICK, 16'hFFFF, 16'h0000);
        put_op(pct_pkg::FUNC_READ, pct_pkg::OFF_STATUS, '0);
        put_op(pct_pkg::FUNC_WRITE, pct_pkg::OFF_STATUS, 16'h0001);
        put_op(pct_pkg::FUNC_WRITE, pct_pkg::OFF_STATUS, 16'hFFFF);
        put_op(pct_pkg::FUNC_WRITE, 16'd4, 16'hFFFF);
        // divider lowered below the running prescale count
        put_op(pct_pkg::FUNC_WRITE, pct_pkg::OFF_CTRL, 16'hFFFF);
        repeat (5) put_op(pct_pkg::FUNC_TICK, '0, '0);
        put_op(pct_pkg::FUNC_WRITE, pct_pkg::OFF_CTRL,
               ctl(1'b1, pct_pkg::PSC_DIV4, 1'b1, 1'b1, 1'b1));
        put_op(pct_pkg::FUNC_TICK, '0, '0);
        // one-shot stop at overflow
        put_op(pct_pkg::FUNC_WRITE, pct_pkg::OFF_COUNT, 16'hFFFF);
        put_op(pct_pkg::FUNC_WRITE, pct_pkg::OFF_CTRL,
               ctl(1'b1, pct_pkg::PSC_DIV1, 1'b0, 1'b1, 1'b0));
        put_op(pct_pkg::FUNC_TICK, '0, '0);
        put_op(pct_pkg::FUNC_READ, pct_pkg::OFF_CTRL, '0);

        for (int seg = 0; seg < NumSegs; seg++) begin
            set_base(seg_base[seg]);
            if (seg == 2) begin
                snd_idle <= 46;
                rcv_idle <= 32;
            end else if (seg == 4) begin
                snd_idle <= 0;
                rcv_idle <= 0;
            end
            repeat (ItemsPerSeg) rand_op();
        end

        drain();
        $display("tb_top: %0d results checked: %0d ticks, %0d reads, %0d writes, %0d unused",
                 checked, n_tick, n_read, n_write, n_none);
        $display("tb_top: bases 0000, FFFF, FFFE and random; stalls both sides, swapped, none");
        if (fails == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/pct_pkg.sv
hdl/pct_core.sv
hdl/prescaled_compare_timer.sv
bench/timer_checker.sv
bench/tb_top.sv
